// ----- sv/sst_pkg.sv -----
`timescale 1ns / 1ps

package sst_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_ABSENT    = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  typedef struct packed {
    logic load;
    logic update;
  } ctrl_t;

endpackage

// ----- sv/sst_if.sv -----
`timescale 1ns / 1ps

interface sst_cmd_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface

interface sst_res_if #(
  parameter int CNT_BITS = 7
);
  logic                valid;
  logic                ready;
  logic                was_present;
  logic [CNT_BITS-1:0] count;
  logic [1:0]          status;

  modport source (output valid, output was_present, output count, output status, input ready);
  modport sink (input valid, input was_present, input count, input status, output ready);
endinterface

// ----- sv/sorted_set_table.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Payload                     Item
// cmd_ch    in   cmd[1:0], value             one set operation
// res_ch    out  was_present, count, status  one result per operation
//
// Each item passes accept (S_IDLE), which registers the broadcast compare of
// all cells, a wait state (S_CMP), then presence reduction and one-step shift
// of the cell row (S_UPD).
// A new item is accepted while the previous result waits in the output register.
// The update stage holds while the output register is still full.
// Synchronous reset empties the set; cell contents need no clearing.

module sorted_set_table
  import sst_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input logic clk,
  input logic rst,
  sst_cmd_if.sink   cmd_ch,
  sst_res_if.source res_ch
);

  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  ctrl_t ctrl;

  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_ch.valid),
    .in_ready  (cmd_ch.ready),
    .out_valid (res_ch.valid),
    .out_ready (res_ch.ready),
    .ctrl      (ctrl)
  );

  sst_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS),
    .CNT_BITS   (CNT_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .cmd         (cmd_ch.cmd),
    .value       (cmd_ch.value),
    .was_present (res_ch.was_present),
    .count       (res_ch.count),
    .status      (res_ch.status)
  );

endmodule

// ----- sv/sst_ctrl.sv -----
`timescale 1ns / 1ps

module sst_ctrl
  import sst_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output ctrl_t ctrl
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CMP;
      end
      S_CMP: state_next = S_UPD;
      S_UPD: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    ctrl.load   = 1'b0;
    ctrl.update = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      S_UPD: begin
        ctrl.update = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (ctrl.update) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

endmodule

// ----- sv/sst_datapath.sv -----
`timescale 1ns / 1ps

module sst_datapath
  import sst_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32,
  parameter int CNT_BITS   = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ctrl_t                        ctrl,
  input  logic [1:0]                   cmd,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         was_present,
  output logic [CNT_BITS-1:0]          count,
  output logic [1:0]                   status
);

  logic signed [VALUE_BITS-1:0] store [CAPACITY];
  logic signed [VALUE_BITS-1:0] key;
  logic [1:0]                   cmd_r;
  logic [CAPACITY-1:0]          lt;
  logic [CAPACITY-1:0]          eq;
  logic [CNT_BITS-1:0]          fill, fill_next;
  logic                         present;
  logic                         do_ins, do_del;
  status_t                      status_next;

  // compare stage: every cell against the key
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key   <= value;
      cmd_r <= cmd;
      for (int i = 0; i < CAPACITY; i++) begin
        lt[i] <= (CNT_BITS'(i) < fill) && (store[i] < value);
        eq[i] <= (CNT_BITS'(i) < fill) && (store[i] == value);
      end
    end
  end

  always_comb begin
    present     = |eq;
    do_ins      = 1'b0;
    do_del      = 1'b0;
    status_next = ST_DONE;
    fill_next   = fill;
    case (cmd_r)
      CMD_INSERT: begin
        if (present) begin
          status_next = ST_DUPLICATE;
        end else if (fill == CNT_BITS'(CAPACITY)) begin
          status_next = ST_FULL;
        end else begin
          do_ins    = 1'b1;
          fill_next = fill + CNT_BITS'(1);
        end
      end
      CMD_DELETE: begin
        if (!present) begin
          status_next = ST_ABSENT;
        end else begin
          do_del    = 1'b1;
          fill_next = fill - CNT_BITS'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctrl.update) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      was_present <= present;
      count       <= fill_next;
      status      <= status_next;
    end
  end

  // shift stage: cells at or above the insert/delete point move by one
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_BITS-1:0] ins_val;
    logic signed [VALUE_BITS-1:0] del_val;

    if (i == 0) begin : g_first
      assign ins_val = key;
    end else begin : g_rest
      assign ins_val = lt[i-1] ? store[i] : store[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign del_val = store[i];
    end else begin : g_inner
      assign del_val = store[i+1];
    end

    always_ff @(posedge clk) begin
      if (ctrl.update && !lt[i]) begin
        if (do_ins) store[i] <= (i == 0) ? key : (lt[(i == 0) ? 0 : i-1] ? key : ins_val);
        else if (do_del) store[i] <= del_val;
      end
    end
  end

endmodule
